// File: rtl/dcc_pkg.sv
package dcc_pkg;

  localparam int unsigned YearW  = 13;
  localparam int unsigned CountW = 17;
  localparam int unsigned DoyW   = 10;

  localparam logic [YearW-1:0] YearCeil = 13'd4096;

  localparam logic [0:0] CfgBaseYear    = 1'b0;
  localparam logic [0:0] CfgBaseWeekday = 1'b1;

  localparam logic [11:0] BaseYearRst    = 12'd1970;
  localparam logic [2:0]  BaseWeekdayRst = 3'd4;

  localparam logic OpDateToCount = 1'b0;
  localparam logic OpCountToDate = 1'b1;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StCheck  = 6'b000010,
    StYear   = 6'b000100,
    StMonth  = 6'b001000,
    StDoy    = 6'b010000,
    StFinish = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic check;
    logic year_step;
    logic year_end;
    logic month_step;
    logic doy_calc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic check_ok;
    logic year_more;
    logic year_fail;
    logic month_more;
  } sts_t;

  typedef struct packed {
    logic [5:0]        week_number;
    logic [2:0]        weekday;
    logic [CountW-1:0] count;
    logic [4:0]        day;
    logic [3:0]        month;
    logic [11:0]       year;
  } res_t;

  // Gregorian rule; mod 25 by reciprocal multiply with one correction step
  function automatic logic is_leap(logic [11:0] y);
    logic [9:0]  x;
    logic [19:0] p;
    logic [5:0]  q;
    logic [9:0]  r;
    x = y[11:2];
    p = {10'b0, x} * 20'd655;
    q = p[19:14];
    r = x - 10'(q * 6'd25);
    if (r >= 10'd25) begin
      r = r - 10'd25;
      q = q + 6'd1;
    end
    if (y[1:0] != 2'b00) return 1'b0;
    if (r != 10'd0) return 1'b1;
    return q[1:0] == 2'b00;
  endfunction

  function automatic logic [4:0] month_len(logic leap, logic [3:0] m);
    case (m)
      4'd2:                         return leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      return 5'd30;
      default:                      return 5'd31;
    endcase
  endfunction

  // Quotient by seven of a small value: reciprocal 146/1024 under-estimates by at most one
  function automatic logic [DoyW-1:0] div7(logic [DoyW-1:0] x);
    logic [2*DoyW-1:0] p;
    logic [DoyW-1:0]   q;
    logic [DoyW-1:0]   r;
    p = {{DoyW{1'b0}}, x} * (2*DoyW)'(146);
    q = p[2*DoyW-1:DoyW];
    r = x - DoyW'(q * DoyW'(7));
    if (r >= DoyW'(7)) q = q + DoyW'(1);
    return q;
  endfunction

  function automatic logic [2:0] mod7(logic [DoyW-1:0] x);
    logic [DoyW-1:0] r;
    r = x - DoyW'(div7(x) * DoyW'(7));
    return r[2:0];
  endfunction

endpackage

// File: rtl/calendar_date_converter_core.sv
// Gregorian date converter: date to day count and day count to date.
//
// Input channel s_axis: tuser carries the operation (0 = date to count,
// 1 = count to date), tdata carries year, month, day and day count. One item
// is taken at a time; tready is high only while the block is idle.
// Output channel m_axis: tuser is the valid flag, tdata the date, count,
// weekday and Sunday-based week number. An invalid date or count gives all
// result fields zero with tuser low.
// Per item: a check step, then one year step per cycle from the base year,
// one month step per cycle, a day-of-year step and the output load; the
// year walk takes the longest. A new item is taken as soon as the result
// sits in the output register, even while the receiver stalls it; the next
// result then waits in the finish step until the output register frees.
// Configuration: cfg_index_i 0 writes the base year, 1 the base weekday; write
// only while idle. Reset loads base year 1970 and weekday Thursday and empties
// the output register.
module calendar_date_converter_core #(
  parameter int unsigned YEAR_SPAN = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // year_in[11:0], month_in[15:12], day_in[20:16], count_in[37:21], zero fill
  input  logic [39:0] s_axis_tdata,
  // operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // year_out[11:0], month_out[15:12], day_out[20:16], count_out[37:21],
  // weekday[40:38], week_number[46:41], zero fill
  output logic [47:0] m_axis_tdata,
  // valid_res
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  dcc_pkg::cmd_t cmd;
  dcc_pkg::sts_t sts;

  // Sequencer: drives the year and month walks, holds the output valid
  dcc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // Datapath: base registers, accumulators and the output register
  dcc_dp #(
    .YEAR_SPAN (YEAR_SPAN)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

// File: rtl/dcc_ctrl.sv
module dcc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  dcc_pkg::sts_t     sts_i,
  output dcc_pkg::cmd_t     cmd_o
);

  dcc_pkg::state_e state_q, state_d;
  logic            mvalid_q, mvalid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      dcc_pkg::StIdle: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = dcc_pkg::StCheck;
        end
      end
      dcc_pkg::StCheck: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.check_ok ? dcc_pkg::StYear : dcc_pkg::StFinish;
      end
      dcc_pkg::StYear: begin
        if (sts_i.year_more) begin
          cmd_o.year_step = 1'b1;
        end else begin
          cmd_o.year_end = 1'b1;
          state_d        = sts_i.year_fail ? dcc_pkg::StFinish : dcc_pkg::StMonth;
        end
      end
      dcc_pkg::StMonth: begin
        if (sts_i.month_more) begin
          cmd_o.month_step = 1'b1;
        end else begin
          state_d = dcc_pkg::StDoy;
        end
      end
      dcc_pkg::StDoy: begin
        cmd_o.doy_calc = 1'b1;
        state_d        = dcc_pkg::StFinish;
      end
      dcc_pkg::StFinish: begin
        if (!mvalid_q || m_axis_tready) begin
          cmd_o.out_load = 1'b1;
          state_d        = dcc_pkg::StIdle;
        end
      end
      default: state_d = dcc_pkg::StIdle;
    endcase
  end

  always_comb begin
    mvalid_d = mvalid_q;
    if (m_axis_tready) mvalid_d = 1'b0;
    if (cmd_o.out_load) mvalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dcc_pkg::StIdle;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

  assign s_axis_tready = (state_q == dcc_pkg::StIdle);
  assign m_axis_tvalid = mvalid_q;

endmodule

// File: rtl/dcc_dp.sv
module dcc_dp #(
  parameter int unsigned YEAR_SPAN = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dcc_pkg::cmd_t cmd_i,
  output dcc_pkg::sts_t sts_o,
  input  logic [39:0]   s_axis_tdata,
  input  logic          s_axis_tuser,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_index_i,
  input  logic [11:0]   cfg_data_i,
  output logic [47:0]   m_axis_tdata,
  output logic          m_axis_tuser
);

  localparam int unsigned YW = dcc_pkg::YearW;
  localparam int unsigned CW = dcc_pkg::CountW;
  localparam int unsigned DW = dcc_pkg::DoyW;

  logic [11:0]   base_year_q;
  logic [2:0]    base_wd_q;

  logic          op_q;
  logic [11:0]   yin_q;
  logic [3:0]    min_q;
  logic [4:0]    din_q;
  logic          ok_q;
  logic [YW-1:0] yr_q;
  logic [3:0]    mo_q;
  logic [CW-1:0] jan1_q;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic [2:0]    wd_q;
  logic [DW-1:0] doy_q;
  logic [4:0]    day_q;

  logic          res_ok_q;
  dcc_pkg::res_t res_q;

  logic [YW-1:0] lim_sum, lim;
  logic          in_leap, yr_leap;
  logic [4:0]    in_mlen, yr_mlen;
  logic [CW-1:0] yr_len;
  logic [3:0]    wd_sum;
  logic [2:0]    wd_next;
  logic [2:0]    first_gap;
  logic [DW-1:0] first_day;
  logic [5:0]    week;
  logic [2:0]    wday;
  dcc_pkg::res_t res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q <= dcc_pkg::BaseYearRst;
      base_wd_q   <= dcc_pkg::BaseWeekdayRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dcc_pkg::CfgBaseYear:    base_year_q <= cfg_data_i;
        dcc_pkg::CfgBaseWeekday: base_wd_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign lim_sum = {1'b0, base_year_q} + YW'(YEAR_SPAN);
  assign lim     = (lim_sum > dcc_pkg::YearCeil) ? dcc_pkg::YearCeil : lim_sum;

  assign in_leap = dcc_pkg::is_leap(yin_q);
  assign in_mlen = dcc_pkg::month_len(in_leap, min_q);
  assign yr_leap = dcc_pkg::is_leap(yr_q[11:0]);
  assign yr_mlen = dcc_pkg::month_len(yr_leap, mo_q);
  assign yr_len  = yr_leap ? CW'(366) : CW'(365);
  assign wd_sum  = {1'b0, wd_q} + (yr_leap ? 4'd2 : 4'd1);
  assign wd_next = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];

  always_comb begin
    sts_o.check_ok = (op_q == dcc_pkg::OpCountToDate) ||
                     ((yin_q >= base_year_q) && ({1'b0, yin_q} < lim) &&
                      (min_q >= 4'd1) && (min_q <= 4'd12) &&
                      (din_q >= 5'd1) && (din_q <= in_mlen));
    if (op_q == dcc_pkg::OpDateToCount) begin
      sts_o.year_more  = yr_q < {1'b0, yin_q};
      sts_o.year_fail  = 1'b0;
      sts_o.month_more = mo_q < min_q;
    end else begin
      sts_o.year_more  = (yr_q < lim) && (rem_q >= yr_len);
      sts_o.year_fail  = !(yr_q < lim);
      sts_o.month_more = rem_q >= CW'(yr_mlen);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= s_axis_tuser;
      yin_q <= s_axis_tdata[11:0];
      min_q <= s_axis_tdata[15:12];
      din_q <= s_axis_tdata[20:16];
      cnt_q <= s_axis_tdata[37:21];
    end
    if (cmd_i.check) begin
      ok_q   <= sts_o.check_ok;
      yr_q   <= {1'b0, base_year_q};
      mo_q   <= 4'd1;
      jan1_q <= '0;
      rem_q  <= (op_q == dcc_pkg::OpCountToDate) ? cnt_q : '0;
      wd_q   <= (base_wd_q == 3'd7) ? 3'd0 : base_wd_q;
    end
    if (cmd_i.year_step) begin
      yr_q   <= yr_q + YW'(1);
      jan1_q <= jan1_q + yr_len;
      wd_q   <= wd_next;
      if (op_q == dcc_pkg::OpCountToDate) rem_q <= rem_q - yr_len;
    end
    if (cmd_i.year_end && sts_o.year_fail) ok_q <= 1'b0;
    if (cmd_i.month_step) begin
      mo_q <= mo_q + 4'd1;
      if (op_q == dcc_pkg::OpDateToCount) rem_q <= rem_q + CW'(yr_mlen);
      else rem_q <= rem_q - CW'(yr_mlen);
    end
    if (cmd_i.doy_calc) begin
      if (op_q == dcc_pkg::OpDateToCount) begin
        // day of the year is the month sum plus the day offset
        cnt_q <= jan1_q + rem_q + CW'(din_q) - CW'(1);
        doy_q <= DW'(rem_q + CW'(din_q) - CW'(1));
        day_q <= din_q;
      end else begin
        doy_q <= DW'(cnt_q - jan1_q);
        day_q <= 5'(rem_q + CW'(1));
      end
    end
    if (cmd_i.out_load) begin
      res_q    <= ok_q ? res_d : '0;
      res_ok_q <= ok_q;
    end
  end

  // Sunday-based week: first Sunday after 1 January falls on day of year first_day
  assign first_gap = 3'd7 - wd_q;
  assign first_day = DW'(first_gap);
  assign week = (doy_q >= first_day) ?
                6'(dcc_pkg::div7(doy_q - first_day) + DW'(2)) : 6'd1;
  assign wday = dcc_pkg::mod7(doy_q + DW'(wd_q));

  always_comb begin
    res_d.year        = yr_q[11:0];
    res_d.month       = mo_q;
    res_d.day         = day_q;
    res_d.count       = cnt_q;
    res_d.weekday     = wday;
    res_d.week_number = week;
  end

  assign m_axis_tdata = {1'b0, res_q};
  assign m_axis_tuser = res_ok_q;

endmodule

// File: rtl/dcc_checker.sv
module dcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // one item in flight: no second accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("invalid result carries data");

  a_fields_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[15:12] >= 4'd1 && m_axis_tdata[15:12] <= 4'd12 &&
      m_axis_tdata[20:16] != 5'd0 && m_axis_tdata[40:38] != 3'd7 &&
      m_axis_tdata[46:41] != 6'd0 && m_axis_tdata[46:41] <= 6'd54)
    else $error("result field out of range");

endmodule

bind calendar_date_converter_core dcc_checker u_dcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_top.sv
module tb_top;

  localparam int unsigned YearSpan  = 256;
  localparam int unsigned NumRows   = 25;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned DrainWait = 300;

  localparam logic ToCount = dcc_pkg::OpDateToCount;
  localparam logic ToDate  = dcc_pkg::OpCountToDate;

  typedef struct {
    logic          ok;
    dcc_pkg::res_t f;
  } date_result_t;

  // One directed item; the expected fields count only where known is set
  typedef struct {
    logic        op;
    int unsigned yr, mo, dy, cnt;
    bit          known, ok;
    int unsigned eyr, emo, edy, ecnt, ewd, ewk;
  } date_row_t;

  // Directed items, run under the reset calendar (1970, Thursday)
  date_row_t directed_rows [NumRows] = '{
    '{ToCount, 1970,  1,  1,      0, 1, 1, 1970, 1,  1,   0, 4,  1},
    '{ToDate,     0,  0,  0,      0, 1, 1, 1970, 1,  1,   0, 4,  1},
    '{ToCount, 1970,  1, 31,      0, 1, 1, 1970, 1, 31,  30, 6,  5},
    '{ToCount, 1970, 12, 31,      0, 1, 1, 1970, 12, 31, 364, 4, 53},
    '{ToCount, 1969, 12, 31,      0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 4095, 15, 31, 131071, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount,    0,  0,  0,      0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 1970,  0,  1,      0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 1970, 13,  1,      0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 1970,  1,  0,      0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 1970,  2, 29,      0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 1970,  4, 31,      0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 2100,  2, 29,      0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 2226,  1,  1,      0, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ToDate,     0,  0,  0, 131071, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ToDate,     0,  0,  0,  93502, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 2000,  2, 29,      0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 1972,  2, 29,      0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 2000, 12, 31,      0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 2225, 12, 31,      0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ToCount, 2047,  8, 31,      0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ToDate,     0,  0,  0,  93501, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ToDate,     0,  0,  0,  10957, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ToDate,     0,  0,  0,  65535, 0, 0, 0, 0, 0, 0, 0, 0},
    '{ToDate,     0,  0,  0,  65536, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  // Calendar settings per phase: base year, base weekday (seven acts as Sunday)
  int unsigned phase_years    [NumPhases] = '{1970, 0, 4095, 3840, 2000, 1, 3900, 1600};
  int unsigned phase_weekdays [NumPhases] = '{4, 0, 6, 7, 6, 3, 1, 5};
  int unsigned phase_items    [NumPhases] = '{165, 165, 165, 165, 165, 165, 165, 165};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [11:0] cfg_data_i;

  logic [11:0] base_year_q;
  logic [2:0]  base_wd_q;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          rx_hold_req;
  int unsigned mismatch_count;

  date_result_t pending_dates [$];

  calendar_date_converter_core #(
    .YEAR_SPAN(YearSpan)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_year(int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      2:             return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // First year past the supported span
  function automatic int unsigned year_ceiling();
    int unsigned lim;
    lim = base_year_q + YearSpan;
    return (lim > 4096) ? 4096 : lim;
  endfunction

  // Number of day counts that map to a supported date
  function automatic int unsigned span_days();
    int unsigned total, y;
    total = 0;
    for (y = base_year_q; y < year_ceiling(); y++) total += days_in_year(y);
    return total;
  endfunction

  // Expected result of one item under the current calendar setting
  function automatic date_result_t convert_date(logic op, logic [11:0] yr, logic [3:0] mo,
                                                logic [4:0] dy, logic [16:0] cnt);
    date_result_t r;
    int unsigned  lim, y, m, d, count, jan1, rem, doy, first, week, i;
    bit           ok;
    r.ok  = 1'b0;
    r.f   = '0;
    lim   = year_ceiling();
    ok    = 1'b1;
    y     = 0;
    m     = 0;
    d     = 0;
    count = 0;
    jan1  = 0;
    if (op == ToCount) begin
      y = yr;
      m = mo;
      d = dy;
      if (y < base_year_q || y >= lim) ok = 1'b0;
      else if (m < 1 || m > 12) ok = 1'b0;
      else if (d < 1 || d > month_days(y, m)) ok = 1'b0;
      if (ok) begin
        for (i = base_year_q; i < y; i++) jan1 += days_in_year(i);
        count = jan1;
        for (i = 1; i < m; i++) count += month_days(y, i);
        count += d - 1;
      end
    end else begin
      count = cnt;
      rem   = count;
      y     = base_year_q;
      while (y < lim && rem >= days_in_year(y)) begin
        rem -= days_in_year(y);
        y++;
      end
      if (y >= lim) begin
        ok = 1'b0;
      end else begin
        jan1 = count - rem;
        m    = 1;
        while (rem >= month_days(y, m)) begin
          rem -= month_days(y, m);
          m++;
        end
        d = rem + 1;
      end
    end
    if (ok) begin
      // Week 1 runs up to the first Sunday after 1 January
      doy   = count - jan1;
      first = 7 - ((base_wd_q + jan1) % 7);
      week  = 1;
      if (doy >= first) week += (doy - first) / 7 + 1;
      r.ok            = 1'b1;
      r.f.year        = y[11:0];
      r.f.month       = m[3:0];
      r.f.day         = d[4:0];
      r.f.count       = count[16:0];
      r.f.weekday     = 3'((base_wd_q + count) % 7);
      r.f.week_number = week[5:0];
    end
    return r;
  endfunction

  function automatic date_result_t row_result(date_row_t row);
    date_result_t r;
    r.ok            = row.ok;
    r.f.year        = 12'(row.eyr);
    r.f.month       = 4'(row.emo);
    r.f.day         = 5'(row.edy);
    r.f.count       = 17'(row.ecnt);
    r.f.weekday     = 3'(row.ewd);
    r.f.week_number = 6'(row.ewk);
    return r;
  endfunction

  // Offer one item from a falling edge; return at the falling edge after acceptance
  // with tvalid still high, so the caller decides whether to drop it.
  task automatic push_item(logic op, logic [11:0] yr, logic [3:0] mo, logic [4:0] dy,
                           logic [16:0] cnt, date_result_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, cnt, dy, mo, yr};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_dates.push_back(want);
    @(negedge clk_i);
  endtask

  // Drop tvalid and hold until every expected result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_calendar(int unsigned yr, int unsigned wd);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= dcc_pkg::CfgBaseYear;
    cfg_data_i  <= 12'(yr);
    @(negedge clk_i);
    // junk above the weekday bits must be dropped by the block
    cfg_index_i <= dcc_pkg::CfgBaseWeekday;
    cfg_data_i  <= {9'($urandom), 3'(wd)};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    base_year_q = 12'(yr);
    base_wd_q   = 3'(wd);
    @(negedge clk_i);
  endtask

  // Mostly well-formed dates and counts, the rest near the span edges or pure noise
  task automatic run_random(int unsigned n);
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [16:0] cnt;
    logic        op;
    int unsigned lim, span, kind, i;
    lim  = year_ceiling();
    span = span_days();
    for (i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      op   = 1'($urandom_range(1));
      yr   = 12'($urandom);
      mo   = 4'($urandom);
      dy   = 5'($urandom);
      cnt  = 17'($urandom);
      if (kind < 92) begin
        yr  = 12'(base_year_q + $urandom_range(lim - base_year_q - 1));
        mo  = 4'($urandom_range(12, 1));
        dy  = 5'($urandom_range(month_days(yr, mo), 1));
        cnt = 17'($urandom_range(span - 1));
      end
      if (kind >= 80 && kind < 92) begin
        case ($urandom_range(6))
          0: yr  = 12'(base_year_q - 1);
          1: yr  = 12'(lim);
          2: yr  = 12'(lim - 1);
          3: dy  = 5'(month_days(yr, mo) + 1);
          4: cnt = 17'(span);
          5: cnt = 17'(span - 1);
          default: begin
            yr = 12'(lim - 1);
            mo = 4'd12;
            dy = 5'd31;
          end
        endcase
      end
      push_item(op, yr, mo, dy, cnt, convert_date(op, yr, mo, dy, cnt));
    end
  endtask

  task automatic report(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    date_result_t  want;
    dcc_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = dcc_pkg::res_t'(m_axis_tdata[46:0]);
      if (pending_dates.size() == 0) begin
        $display("%0t: result with none expected, got valid %0d year %0d count %0d",
                 $time, m_axis_tuser, got.year, got.count);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        report("valid_res", want.ok, m_axis_tuser);
        report("year_out", want.f.year, got.year);
        report("month_out", want.f.month, got.month);
        report("day_out", want.f.day, got.day);
        report("count_out", want.f.count, got.count);
        report("weekday", want.f.weekday, got.weekday);
        report("week_number", want.f.week_number, got.week_number);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here
  initial begin : result_sink
    int unsigned hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = 2000;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int unsigned r, p;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = dcc_pkg::CfgBaseYear;
    cfg_data_i     = '0;
    base_year_q    = dcc_pkg::BaseYearRst;
    base_wd_q      = dcc_pkg::BaseWeekdayRst;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold_req    = 1'b0;
    mismatch_count = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (r = 0; r < NumRows; r++) begin
      push_item(directed_rows[r].op, 12'(directed_rows[r].yr), 4'(directed_rows[r].mo),
                5'(directed_rows[r].dy), 17'(directed_rows[r].cnt),
                directed_rows[r].known ? row_result(directed_rows[r]) :
                convert_date(directed_rows[r].op, 12'(directed_rows[r].yr),
                             4'(directed_rows[r].mo), 5'(directed_rows[r].dy),
                             17'(directed_rows[r].cnt)));
    end
    wait_drained();

    for (p = 0; p < NumPhases; p++) begin
      set_calendar(phase_years[p], phase_weekdays[p]);
      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        1: begin
          tx_idle_pct = 68;
          rx_idle_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_idle_pct = 68;
        end
        default: begin
          tx_idle_pct = 38;
          rx_idle_pct = 38;
        end
      endcase
      // back up the output while items keep coming
      if (p == 4) rx_hold_req = 1'b1;
      run_random(phase_items[p] / 2);
      // let the block run dry mid-phase
      if (p == 5) wait_drained();
      run_random(phase_items[p] - phase_items[p] / 2);
      wait_drained();
    end

    repeat (DrainWait) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("calendar_date_converter_core regression: pass");
    end else begin
      $display("calendar_date_converter_core regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("calendar_date_converter_core regression: fail");
    $finish;
  end

endmodule
